// File: hw/rtl/lfs_rng_pkg.sv
// ----------------------------------------------------------------------------
// lfs_rng_pkg
// Shared types and constants for the lagged-Fibonacci generator with a
// shuffle table: field widths, action codes, sequencer states and the
// control bundles that drive the row of lag cells.
// ----------------------------------------------------------------------------
package lfs_rng_pkg;

    localparam int WORD_W            = 32;
    localparam int BOUND_W           = 31;
    localparam int ACTION_W          = 2;
    localparam int LAG_LENGTH_DEF    = 55;
    localparam int SHUFFLE_DEPTH_DEF = 256;
    localparam int SHORT_LAG         = 24;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEED    = 2'd0,
        ACT_SHUF    = 2'd1,
        ACT_RAW     = 2'd2,
        ACT_BOUNDED = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_ROTATE,
        ST_WARM,
        ST_LOAD,
        ST_HELD,
        ST_SHUF,
        ST_MOD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_DRAW,
        CH_ROTATE,
        CH_FILL
    } chain_op_t;

    typedef enum logic [1:0] {
        FILL_ONE,
        FILL_SEED,
        FILL_SUM
    } fill_sel_t;

    typedef struct packed {
        chain_op_t op;
        fill_sel_t fill_sel;
    } chain_ctrl_t;

    typedef struct packed {
        logic load_fwd;
        logic load_rev;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/lfs_rng_cell.sv
// ----------------------------------------------------------------------------
// lfs_rng_cell
// One word of the lag ring. It takes its left neighbor when the ring steps
// forward and its right neighbor when words are shifted in during a seed.
// ----------------------------------------------------------------------------
module lfs_rng_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfs_rng_pkg::cell_ctrl_t           ctrl,
    input  logic [lfs_rng_pkg::WORD_W-1:0]    d_fwd,
    input  logic [lfs_rng_pkg::WORD_W-1:0]    d_rev,
    output logic [lfs_rng_pkg::WORD_W-1:0]    q
);

    logic [lfs_rng_pkg::WORD_W-1:0] word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (ctrl.load_fwd)
        begin
            word_reg <= d_fwd;
        end
        else if (ctrl.load_rev)
        begin
            word_reg <= d_rev;
        end
    end

    assign q = word_reg;

endmodule

// File: hw/rtl/lfs_rng_chain.sv
// ----------------------------------------------------------------------------
// lfs_rng_chain
// The lag table as a ring of cells. The last cell always holds the word at
// the long-lag position, so a draw is one add of that cell and the short-lag
// tap followed by a one-place rotation.
// ----------------------------------------------------------------------------
module lfs_rng_chain #(
    parameter int LAG_LENGTH = lfs_rng_pkg::LAG_LENGTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfs_rng_pkg::chain_ctrl_t          ctrl,
    input  logic [lfs_rng_pkg::WORD_W-1:0]    seed,
    output logic [lfs_rng_pkg::WORD_W-1:0]    draw_word
);

    logic [lfs_rng_pkg::WORD_W-1:0] q [LAG_LENGTH];
    logic [lfs_rng_pkg::WORD_W-1:0] feed_fwd;
    logic [lfs_rng_pkg::WORD_W-1:0] feed_rev;
    lfs_rng_pkg::cell_ctrl_t        cell_ctrl;

    assign draw_word = q[LAG_LENGTH-1] + q[lfs_rng_pkg::SHORT_LAG-1];

    // During a seed the newest two words sit at the right end of the row.
    always_comb
    begin
        case (ctrl.fill_sel)
            lfs_rng_pkg::FILL_ONE:  feed_rev = lfs_rng_pkg::WORD_W'(1);
            lfs_rng_pkg::FILL_SEED: feed_rev = seed;
            default:                feed_rev = q[LAG_LENGTH-1] + q[LAG_LENGTH-2];
        endcase
    end

    assign feed_fwd = (ctrl.op == lfs_rng_pkg::CH_DRAW) ? draw_word : q[LAG_LENGTH-1];

    assign cell_ctrl.load_fwd = (ctrl.op == lfs_rng_pkg::CH_DRAW) ||
                                (ctrl.op == lfs_rng_pkg::CH_ROTATE);
    assign cell_ctrl.load_rev = (ctrl.op == lfs_rng_pkg::CH_FILL);

    for (genvar k = 0; k < LAG_LENGTH; k++)
    begin : g_cell
        logic [lfs_rng_pkg::WORD_W-1:0] left_w;
        logic [lfs_rng_pkg::WORD_W-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = feed_fwd;
        end
        else
        begin : g_mid_l
            assign left_w = q[k-1];
        end

        if (k == LAG_LENGTH-1)
        begin : g_last
            assign right_w = feed_rev;
        end
        else
        begin : g_mid_r
            assign right_w = q[k+1];
        end

        lfs_rng_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .d_fwd (left_w),
            .d_rev (right_w),
            .q     (q[k])
        );
    end

endmodule

// File: hw/rtl/lfs_rng_shuffle_mem.sv
// ----------------------------------------------------------------------------
// lfs_rng_shuffle_mem
// Single-address shuffle store with a registered read. A read and a write
// at the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module lfs_rng_shuffle_mem #(
    parameter int SHUFFLE_DEPTH = lfs_rng_pkg::SHUFFLE_DEPTH_DEF,
    localparam int ADDR_W       = $clog2(SHUFFLE_DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic                              re,
    input  logic [ADDR_W-1:0]                 addr,
    input  logic [lfs_rng_pkg::WORD_W-1:0]    wdata,
    output logic [lfs_rng_pkg::WORD_W-1:0]    rdata
);

    logic [lfs_rng_pkg::WORD_W-1:0] mem [SHUFFLE_DEPTH];
    logic [lfs_rng_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lfs_rng_mod.sv
// ----------------------------------------------------------------------------
// lfs_rng_mod
// Restoring remainder unit: one dividend bit per cycle, with a one-cycle
// done pulse once the remainder is final.
// ----------------------------------------------------------------------------
module lfs_rng_mod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lfs_rng_pkg::WORD_W-1:0]    dividend,
    input  logic [lfs_rng_pkg::BOUND_W-1:0]   divisor,
    output logic                              done,
    output logic [lfs_rng_pkg::BOUND_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(lfs_rng_pkg::WORD_W);

    logic                              busy_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  bit_cnt_reg;
    logic [lfs_rng_pkg::WORD_W-1:0]    dvd_reg;
    logic [lfs_rng_pkg::BOUND_W-1:0]   div_reg;
    logic [lfs_rng_pkg::BOUND_W-1:0]   rem_reg;
    logic [lfs_rng_pkg::WORD_W-1:0]    trial;
    logic [lfs_rng_pkg::WORD_W-1:0]    diff;
    logic [lfs_rng_pkg::BOUND_W-1:0]   rem_next;

    assign trial = {rem_reg, dvd_reg[lfs_rng_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    // The partial remainder stays below the divisor, so it fits in 31 bits.
    assign rem_next = (trial >= {1'b0, div_reg}) ? diff[lfs_rng_pkg::BOUND_W-1:0]
                                                 : trial[lfs_rng_pkg::BOUND_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= CNT_W'(lfs_rng_pkg::WORD_W - 1);
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[lfs_rng_pkg::WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/lagged_fibonacci_shuffled_rng.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_shuffled_rng
// Additive lagged-Fibonacci generator (lags 24 and 55, modulo 2^32) whose
// output goes through a 256-entry shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_ channel: s_tuser carries the action
//   (seed, shuffled draw, raw draw, bounded draw), s_tdata the bound. Each
//   draw returns one beat on the m_ channel: m_tdata is the word, m_tuser
//   flags a bounded draw asked with a bound of zero. A seed returns nothing.
//   The seed word goes through cfg_we / cfg_wdata; the user must write it
//   only while idle, which the block does not enforce. One command at a time:
//     raw draw and zero-bound error: answered from the accepting state;
//     shuffled draw: the registered shuffle-table read, then the result;
//     bounded draw: the table read, then the bit-serial remainder unit;
//     seed: the accepting cycle, a fill of every lag cell, one rotate, a
//     warm-up of discarded draws, table loads and the held-word load.
//   After reset the lag ring, held word and shuffle table read as zero and
//   the seed register holds 1. A result waits in the output register while
//   the next command is worked on; that command's result then waits inside
//   the block and no further beat is taken until the receiver drains one.
// ----------------------------------------------------------------------------
module lagged_fibonacci_shuffled_rng #(
    parameter int LAG_LENGTH    = lfs_rng_pkg::LAG_LENGTH_DEF,
    parameter int SHUFFLE_DEPTH = lfs_rng_pkg::SHUFFLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] bound, [31] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [0:0]  m_tuser    // [0] bound_error
);

    localparam int WORD_W  = lfs_rng_pkg::WORD_W;
    localparam int BOUND_W = lfs_rng_pkg::BOUND_W;
    localparam int ADDR_W  = $clog2(SHUFFLE_DEPTH);
    localparam int LAG_W   = $clog2(LAG_LENGTH);
    localparam int CNT_W   = (ADDR_W > LAG_W) ? ADDR_W : LAG_W;

    lfs_rng_pkg::state_t      state_reg, state_next;
    lfs_rng_pkg::action_t     act_reg, act_next;
    lfs_rng_pkg::action_t     in_act;
    lfs_rng_pkg::chain_ctrl_t chain_ctrl;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic [BOUND_W-1:0] in_bound;
    logic [WORD_W-1:0]  held_reg, held_next;
    logic               shuf_valid_reg, shuf_valid_next;
    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;
    logic               res_err_reg, res_err_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_value_reg, out_value_next;
    logic               out_err_reg, out_err_next;

    logic [WORD_W-1:0]  draw_word;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;
    logic [WORD_W-1:0]  shuf_word;
    logic               mod_start;
    logic               mod_done;
    logic [BOUND_W-1:0] mod_rem;

    logic               emit;
    logic [WORD_W-1:0]  emit_value;
    logic               emit_err;
    logic               out_free;

    assign in_act   = lfs_rng_pkg::action_t'(s_tuser);
    assign in_bound = s_tdata[BOUND_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == lfs_rng_pkg::ST_IDLE);

    // Entries never written before the first seed read as zero.
    assign shuf_word = shuf_valid_reg ? mem_rdata : '0;

    lfs_rng_chain #(
        .LAG_LENGTH (LAG_LENGTH)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (chain_ctrl),
        .seed      (seed_reg),
        .draw_word (draw_word)
    );

    lfs_rng_shuffle_mem #(
        .SHUFFLE_DEPTH (SHUFFLE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    lfs_rng_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (held_next),
        .divisor   (bound_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfs_rng_pkg::ST_IDLE;
            cnt_reg        <= '0;
            act_reg        <= lfs_rng_pkg::ACT_SEED;
            held_reg       <= '0;
            shuf_valid_reg <= 1'b0;
            seed_reg       <= lfs_rng_pkg::SEED_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            act_reg        <= act_next;
            held_reg       <= held_next;
            shuf_valid_reg <= shuf_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg     <= bound_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        bound_next      = bound_reg;
        held_next       = held_reg;
        shuf_valid_next = shuf_valid_reg;
        res_value_next  = res_value_reg;
        res_err_next    = res_err_reg;
        out_value_next  = out_value_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        chain_ctrl.op       = lfs_rng_pkg::CH_HOLD;
        chain_ctrl.fill_sel = lfs_rng_pkg::FILL_SUM;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = held_reg[WORD_W-1 -: ADDR_W];
        mem_wdata  = draw_word;
        mod_start  = 1'b0;
        emit       = 1'b0;
        emit_value = '0;
        emit_err   = 1'b0;

        case (state_reg)
            lfs_rng_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = in_act;
                    bound_next = in_bound;
                    case (in_act)
                        lfs_rng_pkg::ACT_SEED:
                        begin
                            cnt_next   = '0;
                            state_next = lfs_rng_pkg::ST_FILL;
                        end
                        lfs_rng_pkg::ACT_RAW:
                        begin
                            chain_ctrl.op = lfs_rng_pkg::CH_DRAW;
                            emit          = 1'b1;
                            emit_value    = draw_word;
                        end
                        lfs_rng_pkg::ACT_BOUNDED:
                        begin
                            if (in_bound == '0)
                            begin
                                emit     = 1'b1;
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                chain_ctrl.op = lfs_rng_pkg::CH_DRAW;
                                mem_re        = 1'b1;
                                mem_we        = 1'b1;
                                state_next    = lfs_rng_pkg::ST_SHUF;
                            end
                        end
                        default:
                        begin
                            // The selected entry is read out and refilled
                            // with the fresh additive word in one cycle.
                            chain_ctrl.op = lfs_rng_pkg::CH_DRAW;
                            mem_re        = 1'b1;
                            mem_we        = 1'b1;
                            state_next    = lfs_rng_pkg::ST_SHUF;
                        end
                    endcase
                end
            end

            lfs_rng_pkg::ST_FILL:
            begin
                chain_ctrl.op = lfs_rng_pkg::CH_FILL;
                if (cnt_reg == '0)
                begin
                    chain_ctrl.fill_sel = lfs_rng_pkg::FILL_ONE;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    chain_ctrl.fill_sel = lfs_rng_pkg::FILL_SEED;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LAG_LENGTH - 1))
                begin
                    state_next = lfs_rng_pkg::ST_ROTATE;
                end
            end

            lfs_rng_pkg::ST_ROTATE:
            begin
                // The fill leaves the first word in cell 0; one turn moves
                // the last word into cell 0.
                chain_ctrl.op = lfs_rng_pkg::CH_ROTATE;
                cnt_next      = '0;
                state_next    = lfs_rng_pkg::ST_WARM;
            end

            lfs_rng_pkg::ST_WARM:
            begin
                chain_ctrl.op = lfs_rng_pkg::CH_DRAW;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SHUFFLE_DEPTH - 1))
                begin
                    cnt_next   = CNT_W'(SHUFFLE_DEPTH - 1);
                    state_next = lfs_rng_pkg::ST_LOAD;
                end
            end

            lfs_rng_pkg::ST_LOAD:
            begin
                chain_ctrl.op = lfs_rng_pkg::CH_DRAW;
                mem_we        = 1'b1;
                mem_addr      = cnt_reg[ADDR_W-1:0];
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = lfs_rng_pkg::ST_HELD;
                end
            end

            lfs_rng_pkg::ST_HELD:
            begin
                chain_ctrl.op   = lfs_rng_pkg::CH_DRAW;
                held_next       = draw_word;
                shuf_valid_next = 1'b1;
                state_next      = lfs_rng_pkg::ST_IDLE;
            end

            lfs_rng_pkg::ST_SHUF:
            begin
                held_next = shuf_word;
                if (act_reg == lfs_rng_pkg::ACT_BOUNDED)
                begin
                    mod_start  = 1'b1;
                    state_next = lfs_rng_pkg::ST_MOD;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_value = shuf_word;
                end
            end

            lfs_rng_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    emit       = 1'b1;
                    emit_value = {1'b0, mod_rem};
                end
            end

            lfs_rng_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_err_next   = res_err_reg;
                    state_next     = lfs_rng_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lfs_rng_pkg::ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, otherwise it is parked until the receiver drains a beat.
        if (emit)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_value_next = emit_value;
                out_err_next   = emit_err;
                state_next     = lfs_rng_pkg::ST_IDLE;
            end
            else
            begin
                res_value_next = emit_value;
                res_err_next   = emit_err;
                state_next     = lfs_rng_pkg::ST_OUT;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_err_reg;

endmodule

// File: hw/rtl/lfs_rng_checker.sv
// ----------------------------------------------------------------------------
// lfs_rng_checker
// Port-level checks for the shuffled lagged-Fibonacci generator, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module lfs_rng_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // The output register is empty while reset is held.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result beat shown during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("bound error beat carries a nonzero word");

    // A seed keeps the block busy, so no beat is taken right after it.
    a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == lfs_rng_pkg::ACT_SEED |=> !s_tready)
        else $error("command taken during a seed");

    // A bounded draw with bound zero answers on the next edge when the
    // output register is free.
    a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == lfs_rng_pkg::ACT_BOUNDED &&
        s_tdata[30:0] == 31'd0 && (!m_tvalid || m_tready)
        |=> m_tvalid && m_tuser[0])
        else $error("zero bound did not flag an error");

endmodule

bind lagged_fibonacci_shuffled_rng lfs_rng_checker u_lfs_rng_checker (.*);
